FILE: rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the multipath slot selector.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int KEY_BYTES         = 16;
	localparam int REM_BITS_PER_STEP = 4;
	localparam int MOD_STEPS         = 32 / REM_BITS_PER_STEP;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PRIO,
		ST_MOD,
		ST_SCAN,
		ST_DONE
	} mss_state_t;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_NODE_ID       = 3'd0;
	localparam cfg_idx_t CFG_PER_FLOW_MODE = 3'd1;
	localparam cfg_idx_t CFG_PATH_ID_MODE  = 3'd2;
	localparam cfg_idx_t CFG_LAST_SLOT     = 3'd3;
	localparam cfg_idx_t CFG_SLOT_OCCUPIED = 3'd4;
	localparam cfg_idx_t CFG_ADDR_SHIFT    = 3'd5;
	localparam cfg_idx_t CFG_ADDR_MASK     = 3'd6;

endpackage

FILE: rtl/core/mss_rem_unit.sv
// ----------------------------------------------------------------------------
// mss_rem_unit
// Restoring remainder step: folds a few dividend bits into a running
// remainder modulo a 6-bit modulus (1..32).
// ----------------------------------------------------------------------------
module mss_rem_unit
	import mss_pkg::*;
(
	input  logic [4:0]                   rem_in,
	input  logic [REM_BITS_PER_STEP-1:0] bits_in,
	input  logic [5:0]                   modulus,
	output logic [4:0]                   rem_out
);

	always_comb begin
		logic [5:0] t;
		logic [4:0] r;
		r = rem_in;
		t = '0;
		for (int k = 0; k < REM_BITS_PER_STEP; k++) begin
			t = {r, bits_in[REM_BITS_PER_STEP-1-k]};
			if (t >= modulus) begin
				t = t - modulus;
			end
			r = t[4:0];
		end
		rem_out = r;
	end

endmodule

FILE: rtl/core/multipath_slot_selector_core.sv
// ----------------------------------------------------------------------------
// multipath_slot_selector_core
// Steps: hash mode runs byte-serial ST_HASH, ST_PRIO, ST_MOD with the
//   4-bit-per-cycle remainder unit, then ST_SCAN, one slot per cycle over
//   k (1..last_slot+1) slots, and ST_DONE; round robin starts at ST_MOD.
// A new item is taken only in ST_IDLE, after the last result left ST_DONE.
// Reset: asynchronous; config and control to defaults, round robin pointer 0.
// ----------------------------------------------------------------------------
module multipath_slot_selector_core
	import mss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  cfg_idx_t    cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [31:0] flow_id,
	input  logic [31:0] path_prio,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  slot_index,
	output logic        slot_found
);

	logic [31:0] node_id_q;
	logic        per_flow_mode_q;
	logic        path_id_mode_q;
	logic [4:0]  last_slot_q;
	logic [31:0] slot_occupied_q;
	logic [4:0]  addr_shift_q;
	logic [31:0] addr_mask_q;

	mss_state_t  state_q, state_d;
	logic [4:0]  rr_q;
	logic        out_valid_q;
	logic [4:0]  slot_index_q;
	logic        slot_found_q;

	logic [127:0] key_q;
	logic [31:0]  h_q;
	logic [31:0]  prio_q;
	logic [4:0]   rem_q;
	logic [4:0]   pos_q;
	logic [4:0]   cnt_q;
	logic [4:0]   chosen_q;
	logic         found_q;

	logic        hash_mode;
	logic        accept;
	logic        out_free;
	logic        hash_last;
	logic        mod_last;
	logic        scan_hit;
	logic        scan_end;
	logic [5:0]  modulus;
	logic [4:0]  rem_next;
	logic [31:0] hash_next;
	logic [31:0] src_key;
	logic [31:0] dst_key;
	logic [7:0]  key_byte;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q       <= '0;
			per_flow_mode_q <= 1'b0;
			path_id_mode_q  <= 1'b0;
			last_slot_q     <= '0;
			slot_occupied_q <= '0;
			addr_shift_q    <= '0;
			addr_mask_q     <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_ID:       node_id_q       <= cfg_data;
				CFG_PER_FLOW_MODE: per_flow_mode_q <= cfg_data[0];
				CFG_PATH_ID_MODE:  path_id_mode_q  <= cfg_data[0];
				CFG_LAST_SLOT:     last_slot_q     <= cfg_data[4:0];
				CFG_SLOT_OCCUPIED: slot_occupied_q <= cfg_data;
				CFG_ADDR_SHIFT:    addr_shift_q    <= cfg_data[4:0];
				CFG_ADDR_MASK:     addr_mask_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign hash_mode = per_flow_mode_q | path_id_mode_q;
	assign accept    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign modulus   = {1'b0, last_slot_q} + 6'd1;
	assign hash_last = (cnt_q[3:0] == 4'(KEY_BYTES - 1));
	assign mod_last  = (cnt_q[2:0] == 3'(MOD_STEPS - 1));
	assign scan_hit  = slot_occupied_q[pos_q];
	assign scan_end  = (cnt_q == last_slot_q);
	assign src_key   = (src_addr >> addr_shift_q) & addr_mask_q;
	assign dst_key   = (dst_addr >> addr_shift_q) & addr_mask_q;
	assign key_byte  = key_q[7:0];
	assign hash_next = {h_q[28:0], 3'b000} + h_q + {{24{key_byte[7]}}, key_byte};

	mss_rem_unit u_rem (
		.rem_in  (rem_q),
		.bits_in (h_q[31 -: REM_BITS_PER_STEP]),
		.modulus (modulus),
		.rem_out (rem_next)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = hash_mode ? ST_HASH : ST_MOD;
				end
			end
			ST_HASH: begin
				if (hash_last) begin
					state_d = ST_PRIO;
				end
			end
			ST_PRIO: state_d = ST_MOD;
			ST_MOD: begin
				if (mod_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		out_valid  = out_valid_q;
		slot_index = slot_index_q;
		slot_found = slot_found_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				if (!hash_mode) begin
					rr_q <= (chosen_q == last_slot_q) ? 5'd0 : chosen_q + 5'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q  <= {flow_id, dst_key, src_key, node_id_q};
					h_q    <= hash_mode ? 32'd0 : {27'd0, rr_q};
					prio_q <= path_prio;
					cnt_q  <= '0;
					rem_q  <= '0;
				end
			end
			ST_HASH: begin
				h_q   <= hash_next;
				key_q <= key_q >> 8;
				cnt_q <= hash_last ? 5'd0 : cnt_q + 5'd1;
			end
			ST_PRIO: begin
				if (path_id_mode_q) begin
					h_q <= h_q + prio_q;
				end
			end
			ST_MOD: begin
				rem_q <= rem_next;
				h_q   <= h_q << REM_BITS_PER_STEP;
				cnt_q <= mod_last ? 5'd0 : cnt_q + 5'd1;
				if (mod_last) begin
					pos_q <= rem_next;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_end) begin
					chosen_q <= pos_q;
					found_q  <= scan_hit;
				end else begin
					pos_q <= (pos_q == last_slot_q) ? 5'd0 : pos_q + 5'd1;
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					slot_index_q <= chosen_q;
					slot_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_found_is_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_found |-> slot_occupied_q[slot_index])
		else $error("reported slot is not occupied");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slot_index <= last_slot_q)
		else $error("slot index beyond last slot");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> pos_q <= last_slot_q && cnt_q <= last_slot_q)
		else $error("scan position out of range");

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |=> rem_q <= last_slot_q)
		else $error("remainder not below modulus");

endmodule

FILE: tb/sv/multipath_slot_selector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipath_slot_selector_core_tb
// Drives packets through the slot selector in round robin and flow hash
// modes over a series of register settings, predicts each chosen slot and
// found flag, and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
module multipath_slot_selector_core_tb;
	import mss_pkg::*;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] flow;
		logic [31:0] prio;
	} pkt_t;

	typedef struct packed {
		logic [4:0] slot;
		logic       found;
	} sel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_index = CFG_NODE_ID;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] src_addr = 32'd0;
	logic [31:0] dst_addr = 32'd0;
	logic [31:0] flow_id = 32'd0;
	logic [31:0] path_prio = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [4:0]  slot_index;
	logic        slot_found;

	// shadow of the block's registers and round robin pointer
	logic [31:0] sh_node = 32'd0;
	logic        sh_per_flow = 1'b0;
	logic        sh_path_id = 1'b0;
	logic [4:0]  sh_last = 5'd0;
	logic [31:0] sh_occ = 32'd0;
	logic [4:0]  sh_shift = 5'd0;
	logic [31:0] sh_mask = 32'hFFFF_FFFF;
	logic [4:0]  rr_next = 5'd0;

	pkt_t pkt_q[$];
	sel_t sel_q[$];
	pkt_t cur_pkt;
	sel_t want;
	logic in_took = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	int   hold_req = 0;
	int   hold_done = 0;
	bit   no_idle = 1'b0;
	int   mismatch_cnt = 0;

	multipath_slot_selector_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.flow_id    (flow_id),
		.path_prio  (path_prio),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.slot_found (slot_found)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] mix_word(logic [31:0] h, logic [31:0] w);
		logic [7:0] b;
		for (int k = 0; k < 4; k++) begin
			b = w[8*k +: 8];
			h = h * 32'd9 + {{24{b[7]}}, b};
		end
		return h;
	endfunction

	function automatic sel_t select_slot(pkt_t p);
		logic [31:0] h;
		logic [5:0]  m;
		logic [5:0]  start;
		logic [5:0]  s;
		sel_t        r;
		bit          hit;
		hit = 1'b0;
		m = {1'b0, sh_last} + 6'd1;
		if (sh_per_flow || sh_path_id) begin
			h = mix_word(32'd0, sh_node);
			h = mix_word(h, (p.src >> sh_shift) & sh_mask);
			h = mix_word(h, (p.dst >> sh_shift) & sh_mask);
			h = mix_word(h, p.flow);
			if (sh_path_id)
				h = h + p.prio;
			start = 6'(h % m);
		end else begin
			start = 6'({1'b0, rr_next} % m);
		end
		r.slot = 5'((start + m - 1) % m);
		r.found = 1'b0;
		for (int i = 0; i < 32; i++) begin
			if (!hit && i < m) begin
				s = 6'((start + i) % m);
				if (sh_occ[s[4:0]]) begin
					hit = 1'b1;
					r.slot = s[4:0];
					r.found = 1'b1;
				end
			end
		end
		if (!(sh_per_flow || sh_path_id))
			rr_next = 5'((r.slot + 1) % m);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// accepted items, result checking
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			sel_q.push_back(select_slot({src_addr, dst_addr, flow_id, path_prio}));
		if (arst_n && out_valid && !out_stall) begin
			if (sel_q.size() == 0) begin
				report_mismatch($sformatf("result slot %0d found %0b with none pending",
					slot_index, slot_found));
			end else begin
				want = sel_q.pop_front();
				if (slot_index !== want.slot)
					report_mismatch($sformatf("slot_index %0d, predicted %0d",
						slot_index, want.slot));
				if (slot_found !== want.found)
					report_mismatch($sformatf("slot_found %0b, predicted %0b",
						slot_found, want.found));
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		if (in_valid && !in_took) begin
			// stalled: hold the item
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 1'b0;
		end else if (arst_n && pkt_q.size() > 0) begin
			if (!no_idle && $urandom_range(0, 4) == 0) begin
				send_gap <= $urandom_range(0, 5);
				in_valid <= 1'b0;
			end else begin
				cur_pkt = pkt_q.pop_front();
				in_valid <= 1'b1;
				src_addr <= cur_pkt.src;
				dst_addr <= cur_pkt.dst;
				flow_id <= cur_pkt.flow;
				path_prio <= cur_pkt.prio;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8080_8080;
			3: return 32'h7F7F_7F7F;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(logic [31:0] s, logic [31:0] d, logic [31:0] f, logic [31:0] p);
		pkt_q.push_back({s, d, f, p});
	endtask

	task automatic wait_drained();
		while (!(pkt_q.size() == 0 && !in_valid && sel_q.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_NODE_ID:       sh_node = val;
			CFG_PER_FLOW_MODE: sh_per_flow = val[0];
			CFG_PATH_ID_MODE:  sh_path_id = val[0];
			CFG_LAST_SLOT:     sh_last = val[4:0];
			CFG_SLOT_OCCUPIED: sh_occ = val;
			CFG_ADDR_SHIFT:    sh_shift = val[4:0];
			CFG_ADDR_MASK:     sh_mask = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_setup();
		logic [31:0] occ;
		write_reg(CFG_NODE_ID, rand_word());
		write_reg(CFG_PER_FLOW_MODE, $urandom);
		write_reg(CFG_PATH_ID_MODE, $urandom);
		case ($urandom_range(0, 4))
			0: write_reg(CFG_LAST_SLOT, 32'd0);
			1: write_reg(CFG_LAST_SLOT, 32'd31);
			2: write_reg(CFG_LAST_SLOT, $urandom_range(1, 4));
			default: write_reg(CFG_LAST_SLOT, $urandom);
		endcase
		case ($urandom_range(0, 5))
			0: occ = 32'd0;
			1: occ = 32'hFFFF_FFFF;
			2: occ = 32'd1 << $urandom_range(0, 31);
			3: occ = $urandom & $urandom & $urandom;
			default: occ = $urandom;
		endcase
		write_reg(CFG_SLOT_OCCUPIED, occ);
		write_reg(CFG_ADDR_SHIFT, $urandom);
		write_reg(CFG_ADDR_MASK, rand_word());
	endtask

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one slot, none occupied
		push_item(32'd0, 32'd0, 32'd0, 32'd0);
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();

		// round robin over all slots, then pointer beyond a lowered last slot
		write_reg(CFG_LAST_SLOT, 32'd31);
		write_reg(CFG_SLOT_OCCUPIED, 32'hFFFF_FFFF);
		push_item(32'h1, 32'h2, 32'h3, 32'h4);
		push_item(32'h5, 32'h6, 32'h7, 32'h8);
		wait_drained();
		write_reg(CFG_SLOT_OCCUPIED, 32'd1 << 20);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();
		write_reg(CFG_SLOT_OCCUPIED, 32'd0);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();
		write_reg(CFG_LAST_SLOT, 32'd7);
		write_reg(CFG_SLOT_OCCUPIED, 32'h0000_0081);
		push_item($urandom, $urandom, $urandom, $urandom);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();

		// per-flow hash with byte sign extremes
		write_reg(CFG_PER_FLOW_MODE, 32'd1);
		write_reg(CFG_NODE_ID, 32'hFFFF_FFFF);
		write_reg(CFG_LAST_SLOT, 32'd31);
		write_reg(CFG_SLOT_OCCUPIED, $urandom);
		write_reg(CFG_ADDR_SHIFT, 32'd0);
		write_reg(CFG_ADDR_MASK, 32'hFFFF_FFFF);
		push_item(32'd0, 32'd0, 32'd0, 32'd0);
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(32'h8080_8080, 32'h8080_8080, 32'h8080_8080, 32'h8080_8080);
		push_item(32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h7F7F_7F7F);
		wait_drained();
		write_reg(CFG_ADDR_SHIFT, 32'd31);
		write_reg(CFG_ADDR_MASK, 32'd0);
		push_item(32'hFFFF_FFFF, 32'h8000_0000, $urandom, $urandom);
		push_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom);
		wait_drained();
		write_reg(CFG_SLOT_OCCUPIED, 32'd0);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();

		// path id mode adds the priority
		write_reg(CFG_PER_FLOW_MODE, 32'd0);
		write_reg(CFG_PATH_ID_MODE, 32'd1);
		write_reg(CFG_SLOT_OCCUPIED, 32'hA5A5_5A5A);
		push_item($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
		push_item($urandom, $urandom, $urandom, 32'd0);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();
		write_reg(CFG_PER_FLOW_MODE, 32'd1);
		push_item($urandom, $urandom, $urandom, $urandom);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			random_setup();
			if (ph == 2 || ph == 7)
				hold_req++;
			if (ph >= 10)
				no_idle = 1'b1;
			for (int n = 0; n < 52; n++) begin
				if (ph == 5 && n == 26)
					wait_drained();
				push_item(rand_word(), rand_word(), rand_word(), rand_word());
			end
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (sel_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", sel_q.size()));
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
